// ===== sv/meg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the midpoint ellipse generator.
// No dependencies; imported by meg_front, meg_back and the top level.
package meg_pkg;

    localparam int COORD_W = 16;
    localparam int RAD_W   = 7;
    localparam int SQ_W    = 2 * RAD_W;
    localparam int X_W     = RAD_W + 1;
    localparam int Y_W     = RAD_W + 2;
    localparam int SLOPE_W = 25;
    localparam int DEC_W   = 32;
    localparam int MA_W    = SQ_W;
    localparam int MB_W    = 2 * (X_W + 1);
    localparam int PROD_W  = MA_W + MB_W;
    localparam int ACC_W   = PROD_W + 3;
    localparam int OP_W    = 2;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_cmd_kind;

    typedef enum logic {
        KIND_POINT = 1'b0,
        KIND_SPAN  = 1'b1
    } t_item_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [RAD_W-1:0]   rx;
        logic [RAD_W-1:0]   ry;
        logic               fill;
        logic [OP_W-1:0]    op;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_out;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SQ_RX,
        B_SQ_RY,
        B_MUL_T,
        B_INIT_D,
        B_STEP_A,
        B_STEP_B,
        B_EMIT,
        B_R2_HX,
        B_R2_A,
        B_R2_YM,
        B_R2_B,
        B_R2_C,
        B_R2_D
    } t_back_state;

endpackage

// ===== sv/meg_front.sv =====
`timescale 1ns / 1ps
// Front end: takes input transfers, decodes the command and holds it
// in a two-entry queue for the back end. Uses meg_pkg.
module meg_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_command,
    input  logic [meg_pkg::COORD_W-1:0] i_center_x,
    input  logic [meg_pkg::COORD_W-1:0] i_center_y,
    input  logic [meg_pkg::RAD_W-1:0]   i_radius_x,
    input  logic [meg_pkg::RAD_W-1:0]   i_radius_y,
    input  logic                        i_fill_mode,
    input  logic [meg_pkg::OP_W-1:0]    i_draw_value,
    input  logic                        i_pop,
    output meg_pkg::t_q_out             o_q
);
    import meg_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_cmd       w_in;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_in.kind = i_command ? CMD_STEP : CMD_START;
        w_in.cx   = i_center_x;
        w_in.cy   = i_center_y;
        w_in.rx   = i_radius_x;
        w_in.ry   = i_radius_y;
        w_in.fill = i_fill_mode;
        w_in.op   = i_draw_value;
    end

    assign o_stall   = r_cnt[1];
    assign w_push    = i_valid && !o_stall;
    assign w_pop     = i_pop && (r_cnt != 2'd0);
    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.cmd   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_in;
        end
    end

endmodule

// ===== sv/meg_back.sv =====
`timescale 1ns / 1ps
// Back end: runs the two-region midpoint ellipse on one shared multiplier
// and sends the items through an output register. Uses meg_pkg.
module meg_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  meg_pkg::t_q_out             i_q,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_item_kind,
    output logic [meg_pkg::COORD_W-1:0] o_x_start,
    output logic [meg_pkg::COORD_W-1:0] o_x_end,
    output logic [meg_pkg::COORD_W-1:0] o_y_pos,
    output logic [meg_pkg::OP_W-1:0]    o_pixel_op,
    output logic                        o_last
);
    import meg_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic [COORD_W-1:0]      r_cx;
    logic [COORD_W-1:0]      r_cy;
    logic [RAD_W-1:0]        r_rx;
    logic [RAD_W-1:0]        r_ry;
    logic                    r_fill;
    logic [OP_W-1:0]         r_op;
    logic [SQ_W-1:0]         r_rxsq;
    logic [SQ_W-1:0]         r_rysq;
    logic [X_W-1:0]          r_x;
    logic signed [Y_W-1:0]   r_y;
    logic signed [SLOPE_W-1:0] r_sx;
    logic signed [SLOPE_W-1:0] r_sy;
    logic signed [DEC_W-1:0] r_d;
    logic                    r_r2;
    logic                    r_active;
    logic [PROD_W-1:0]       r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_br;
    logic                    r_enter;
    logic                    r_done;
    logic [COORD_W-1:0]      r_exp;
    logic [COORD_W-1:0]      r_exn;
    logic [COORD_W-1:0]      r_eyp;
    logic [COORD_W-1:0]      r_eyn;
    logic [1:0]              r_k;

    logic                    r_out_valid;
    t_item_kind              r_out_kind;
    logic [COORD_W-1:0]      r_out_xs;
    logic [COORD_W-1:0]      r_out_xe;
    logic [COORD_W-1:0]      r_out_y;
    logic [OP_W-1:0]         r_out_op;
    logic                    r_out_last;

    logic [MA_W-1:0]         w_ma;
    logic [MB_W-1:0]         w_mb;
    logic [PROD_W-1:0]       w_prod;
    logic                    w_out_free;
    logic                    w_emit;
    logic [1:0]              w_last_k;
    logic [X_W:0]            w_hx;
    logic signed [Y_W:0]     w_ym;
    logic [Y_W:0]            w_ym_abs;
    logic signed [SLOPE_W-1:0] w_rxsq2;
    logic signed [SLOPE_W-1:0] w_rysq2;
    logic signed [SLOPE_W-1:0] w_sx_inc;
    logic signed [SLOPE_W-1:0] w_sy_dec;
    logic signed [Y_W-1:0]   w_y_dec;
    logic [COORD_W-1:0]      w_xe;
    logic [COORD_W-1:0]      w_ye;
    logic signed [DEC_W-1:0] w_base;
    logic signed [DEC_W-1:0] w_sxe;
    logic signed [DEC_W-1:0] w_sye;
    logic signed [DEC_W-1:0] w_d_new;
    logic signed [ACC_W-1:0] w_prod4;
    logic signed [ACC_W-1:0] w_q_base;
    logic signed [ACC_W-1:0] w_q;
    logic signed [ACC_W-1:0] w_q_adj;
    t_item_kind              w_kind;
    logic [COORD_W-1:0]      w_xs;
    logic [COORD_W-1:0]      w_xend;
    logic [COORD_W-1:0]      w_yo;

    // shared datapath terms
    assign w_hx     = {r_x, 1'b1};
    assign w_ym     = {r_y[Y_W-1], r_y} - (Y_W+1)'(1);
    assign w_ym_abs = w_ym[Y_W] ? (Y_W+1)'(-w_ym) : (Y_W+1)'(w_ym);
    assign w_rxsq2  = {{(SLOPE_W-SQ_W-1){1'b0}}, r_rxsq, 1'b0};
    assign w_rysq2  = {{(SLOPE_W-SQ_W-1){1'b0}}, r_rysq, 1'b0};
    assign w_sx_inc = r_sx + w_rysq2;
    assign w_sy_dec = r_sy - w_rxsq2;
    assign w_y_dec  = r_y - Y_W'(1);
    assign w_xe     = {{(COORD_W-X_W){1'b0}}, r_x};
    assign w_ye     = {{(COORD_W-Y_W){r_y[Y_W-1]}}, r_y};
    assign w_prod   = {{(PROD_W-MA_W){1'b0}}, w_ma} * {{(PROD_W-MB_W){1'b0}}, w_mb};

    // decision update after a step
    assign w_base  = r_r2 ? {{(DEC_W-SQ_W){1'b0}}, r_rxsq} : {{(DEC_W-SQ_W){1'b0}}, r_rysq};
    assign w_sxe   = (!r_r2 || !r_br) ? {{(DEC_W-SLOPE_W){r_sx[SLOPE_W-1]}}, r_sx} : '0;
    assign w_sye   = (r_r2 || !r_br) ? {{(DEC_W-SLOPE_W){r_sy[SLOPE_W-1]}}, r_sy} : '0;
    assign w_d_new = r_d + w_base + w_sxe - w_sye;

    // quarter-unit start values, truncated toward zero
    assign w_prod4  = {1'b0, r_prod, 2'b00};
    assign w_q_base = (r_state == B_INIT_D)
                    ? ({{(ACC_W-SQ_W-2){1'b0}}, r_rysq, 2'b00}
                       + {{(ACC_W-SQ_W){1'b0}}, r_rxsq})
                    : r_acc;
    assign w_q      = w_q_base - w_prod4;
    assign w_q_adj  = w_q + (w_q[ACC_W-1] ? ACC_W'(3) : ACC_W'(0));

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_last_k   = r_fill ? 2'd1 : 2'd3;

    // item selection
    always_comb begin
        if (r_fill) begin
            w_kind = KIND_SPAN;
            w_xs   = r_exn;
            w_xend = r_exp;
            w_yo   = r_k[0] ? r_eyn : r_eyp;
        end else begin
            w_kind = KIND_POINT;
            w_xs   = (r_k[0] ^ r_k[1]) ? r_exn : r_exp;
            w_xend = w_xs;
            w_yo   = r_k[1] ? r_eyn : r_eyp;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_q.valid) begin
                    if (i_q.cmd.kind == CMD_START) begin
                        n_state = B_SQ_RX;
                    end else if (r_active) begin
                        n_state = B_STEP_A;
                    end
                end
            end
            B_SQ_RX:  n_state = B_SQ_RY;
            B_SQ_RY:  n_state = B_MUL_T;
            B_MUL_T:  n_state = B_INIT_D;
            B_INIT_D: n_state = (r_prod == '0) ? B_R2_HX : B_IDLE;
            B_STEP_A: n_state = B_STEP_B;
            B_STEP_B: n_state = B_EMIT;
            B_EMIT: begin
                if (w_out_free && (r_k == w_last_k)) begin
                    n_state = r_enter ? B_R2_HX : B_IDLE;
                end
            end
            B_R2_HX:  n_state = B_R2_A;
            B_R2_A:   n_state = B_R2_YM;
            B_R2_YM:  n_state = B_R2_B;
            B_R2_B:   n_state = B_R2_C;
            B_R2_C:   n_state = B_R2_D;
            B_R2_D:   n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop  = 1'b0;
        w_emit = 1'b0;
        w_ma   = '0;
        w_mb   = '0;
        case (r_state)
            B_IDLE:  o_pop = i_q.valid;
            B_EMIT:  w_emit = w_out_free;
            B_SQ_RX: begin
                w_ma = MA_W'(r_rx);
                w_mb = MB_W'(r_rx);
            end
            B_SQ_RY: begin
                w_ma = MA_W'(r_ry);
                w_mb = MB_W'(r_ry);
            end
            B_MUL_T: begin
                w_ma = r_rxsq;
                w_mb = MB_W'(r_ry);
            end
            B_R2_HX: begin
                w_ma = MA_W'(w_hx);
                w_mb = MB_W'(w_hx);
            end
            B_R2_A: begin
                w_ma = r_rysq;
                w_mb = r_prod[MB_W-1:0];
            end
            B_R2_YM: begin
                w_ma = MA_W'(w_ym_abs);
                w_mb = MB_W'(w_ym_abs);
            end
            B_R2_B: begin
                w_ma = r_rxsq;
                w_mb = r_prod[MB_W-1:0];
            end
            B_R2_C: begin
                w_ma = r_rxsq;
                w_mb = MB_W'(r_rysq);
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_active    <= 1'b0;
            r_r2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == B_IDLE && i_q.valid && i_q.cmd.kind == CMD_START) begin
                r_active <= 1'b1;
                r_r2     <= 1'b0;
            end
            if (r_state == B_STEP_A && r_r2 && w_y_dec[Y_W-1]) begin
                r_active <= 1'b0;
            end
            if (r_state == B_R2_D) begin
                r_r2 <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (w_emit) begin
            r_out_kind <= w_kind;
            r_out_xs   <= w_xs;
            r_out_xe   <= w_xend;
            r_out_y    <= w_yo;
            r_out_op   <= r_op;
            r_out_last <= r_done && (r_k == w_last_k);
            r_k        <= r_k + 2'd1;
        end
        case (r_state)
            B_IDLE: begin
                if (i_q.valid && i_q.cmd.kind == CMD_START) begin
                    r_cx   <= i_q.cmd.cx;
                    r_cy   <= i_q.cmd.cy;
                    r_rx   <= i_q.cmd.rx;
                    r_ry   <= i_q.cmd.ry;
                    r_fill <= i_q.cmd.fill;
                    r_op   <= i_q.cmd.op;
                    r_x    <= '0;
                    r_y    <= {{(Y_W-RAD_W){1'b0}}, i_q.cmd.ry};
                    r_sx   <= '0;
                end
            end
            B_SQ_RY: r_rxsq <= r_prod[SQ_W-1:0];
            B_MUL_T: r_rysq <= r_prod[SQ_W-1:0];
            B_INIT_D: begin
                r_sy <= {1'b0, r_prod[SLOPE_W-3:0], 1'b0};
                r_d  <= w_q_adj[DEC_W+1:2];
            end
            B_STEP_A: begin
                r_exp  <= r_cx + w_xe;
                r_exn  <= r_cx - w_xe;
                r_eyp  <= r_cy + w_ye;
                r_eyn  <= r_cy - w_ye;
                r_done <= r_r2 && w_y_dec[Y_W-1];
                if (!r_r2) begin
                    r_br <= r_d[DEC_W-1];
                    r_x  <= r_x + X_W'(1);
                    r_sx <= w_sx_inc;
                    if (!r_d[DEC_W-1]) begin
                        r_y  <= w_y_dec;
                        r_sy <= w_sy_dec;
                    end
                end else begin
                    r_br <= !r_d[DEC_W-1] && (r_d != '0);
                    r_y  <= w_y_dec;
                    r_sy <= w_sy_dec;
                    if (r_d[DEC_W-1] || r_d == '0) begin
                        r_x  <= r_x + X_W'(1);
                        r_sx <= w_sx_inc;
                    end
                end
            end
            B_STEP_B: begin
                r_d     <= w_d_new;
                r_enter <= !r_r2 && !(r_sx < r_sy);
                r_k     <= 2'd0;
            end
            B_R2_YM: r_acc <= {{(ACC_W-PROD_W){1'b0}}, r_prod};
            B_R2_C:  r_acc <= r_acc + w_prod4;
            B_R2_D:  r_d   <= w_q_adj[DEC_W+1:2];
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_item_kind = r_out_kind;
    assign o_x_start   = r_out_xs;
    assign o_x_end     = r_out_xe;
    assign o_y_pos     = r_out_y;
    assign o_pixel_op  = r_out_op;
    assign o_last      = r_out_last;

endmodule

// ===== sv/midpoint_ellipse_generator.sv =====
`timescale 1ns / 1ps
// Top level of the midpoint ellipse generator: front queue plus back end.
// Uses meg_pkg, meg_front and meg_back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   command  | i_valid / o_stall  | command, center, radii, fill, draw value
//   items    | o_valid / i_stall  | kind, x start/end, row, pixel op, last
//
// A start runs B_SQ_RX to B_INIT_D; a step runs B_STEP_A and B_STEP_B,
// then sends four points (outline) or two spans (fill) through the
// one-item output register; entering region two adds B_R2_HX to B_R2_D.
// Reset is synchronous, active low, and drops any queued commands. The
// two-entry queue keeps accepting, until full, while items wait on i_stall.
module midpoint_ellipse_generator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_command,
    input  logic [meg_pkg::COORD_W-1:0] i_center_x,
    input  logic [meg_pkg::COORD_W-1:0] i_center_y,
    input  logic [meg_pkg::RAD_W-1:0]   i_radius_x,
    input  logic [meg_pkg::RAD_W-1:0]   i_radius_y,
    input  logic                        i_fill_mode,
    input  logic [meg_pkg::OP_W-1:0]    i_draw_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_item_kind,
    output logic [meg_pkg::COORD_W-1:0] o_x_start,
    output logic [meg_pkg::COORD_W-1:0] o_x_end,
    output logic [meg_pkg::COORD_W-1:0] o_y_pos,
    output logic [meg_pkg::OP_W-1:0]    o_pixel_op,
    output logic                        o_last
);
    import meg_pkg::*;

    t_q_out w_q;
    logic   w_pop;

    meg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_radius_x  (i_radius_x),
        .i_radius_y  (i_radius_y),
        .i_fill_mode (i_fill_mode),
        .i_draw_value(i_draw_value),
        .i_pop       (w_pop),
        .o_q         (w_q)
    );

    meg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q        (w_q),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item_kind(o_item_kind),
        .o_x_start  (o_x_start),
        .o_x_end    (o_x_end),
        .o_y_pos    (o_y_pos),
        .o_pixel_op (o_pixel_op),
        .o_last     (o_last)
    );

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q.valid)
        else $error("back end popped an empty queue");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_point_one_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item_kind == KIND_POINT) |-> (o_x_start == o_x_end))
        else $error("point transfer with differing columns");

endmodule
